FILE: rtl/at_reply_line_and_ipd_parser_macros.svh
// Assertion macros shared by the reply-line parser RTL.
`ifndef AT_REPLY_LINE_AND_IPD_PARSER_MACROS_SVH
`define AT_REPLY_LINE_AND_IPD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define ARPL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ARPL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ARPL_ASSERT_NOW(lbl, ante, cons, msg)
`define ARPL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/arpl_pkg.sv
// Shared types, constants and helpers of the reply-line and IPD parser.
package arpl_pkg;

	localparam int LINE_LEN  = 32;
	localparam int IDX_W     = $clog2(LINE_LEN);
	localparam int CNT_W     = $clog2(LINE_LEN + 1);
	localparam int READY_LEN = 5;
	localparam int IPD_MIN   = 4;

	localparam logic [1:0] KIND_LINE = 2'd0;
	localparam logic [1:0] KIND_PAY  = 2'd1;
	localparam logic [1:0] KIND_MARK = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;

	typedef struct packed {
		logic push;
		logic flush;
		logic ipd_take;
		logic load_pay;
		logic dec_left;
		logic load_marker;
		logic rd;
		logic load_line;
	} arpl_cmd_t;

	typedef struct packed {
		logic eol;
		logic blank;
		logic plus;
		logic gt;
		logic colon;
		logic go_push;
		logic go_hold;
		logic ipd_hit;
		logic size_zero;
		logic left_zero;
		logic pay_last;
		logic em_last;
		logic out_free;
	} arpl_sts_t;

	function automatic logic [7:0] ready_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h72;
			3'd1: c = 8'h65;
			3'd2: c = 8'h61;
			3'd3: c = 8'h64;
			3'd4: c = 8'h79;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/arpl_dpath.sv
// Datapath: line store, incremental line checks, number parser, output register.
`include "at_reply_line_and_ipd_parser_macros.svh"
module arpl_dpath import arpl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  arpl_cmd_t  cmd,
	output arpl_sts_t  sts,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [7:0] conn_id,
	output logic       last
);

	typedef enum logic [4:0] {
		P_SEEK_ID = 5'b00001,
		P_ID      = 5'b00010,
		P_SEEK_SZ = 5'b00100,
		P_SZ      = 5'b01000,
		P_DONE    = 5'b10000
	} phase_t;

	logic [7:0]       mem [LINE_LEN];
	logic [7:0]       rd_q;
	logic [CNT_W-1:0] wi_q, trim_q, len_q;
	logic [IDX_W-1:0] em_idx_q;
	logic             rm_q, ipd_q, ready_seen_q;
	phase_t           phase_q, phase_d;
	logic [7:0]       id_acc_q, id_d, pid_q;
	logic [15:0]      sz_acc_q, sz_d, left_q;
	logic             valid_q, last_q;
	logic [1:0]       kind_q;
	logic [7:0]       byte_q, cid_q;

	logic             wrap, is_dig, is_blank, rm_d, ipd_d;
	logic             gate_push, gate_hold, em_last, load_any;
	logic [3:0]       dig;
	logic [IDX_W-1:0] wp;
	logic [CNT_W-1:0] wi_d, trim_d;
	logic [11:0]      id_mul;
	logic [19:0]      sz_mul;
	logic [7:0]       id_sat;
	logic [15:0]      sz_sat;

	assign is_dig   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign dig      = rx_byte[3:0];
	assign is_blank = (rx_byte == CH_SP) || (rx_byte == CH_TAB);
	assign wrap     = wi_q >= CNT_W'(LINE_LEN);
	assign wp       = wrap ? '0 : wi_q[IDX_W-1:0];
	assign wi_d     = CNT_W'(wp) + CNT_W'(1);
	assign trim_d   = is_blank ? ((wp == '0) ? '0 : trim_q) : wi_d;

	assign id_mul = 12'({id_acc_q, 3'b000}) + 12'({id_acc_q, 1'b0}) + 12'(dig);
	assign sz_mul = 20'({sz_acc_q, 3'b000}) + 20'({sz_acc_q, 1'b0}) + 20'(dig);
	assign id_sat = (id_mul > 12'd255) ? 8'hFF : id_mul[7:0];
	assign sz_sat = (sz_mul > 20'd65535) ? 16'hFFFF : sz_mul[15:0];

	always_comb begin
		if (wp == '0) begin
			rm_d = (rx_byte == ready_char(3'd0));
		end else if (wp < IDX_W'(READY_LEN)) begin
			rm_d = rm_q && (rx_byte == ready_char(wp[2:0]));
		end else begin
			rm_d = rm_q;
		end
	end

	always_comb begin
		if (wp == '0) begin
			ipd_d = 1'b1;
		end else if (wp == IDX_W'(1)) begin
			ipd_d = (rx_byte == CH_I);
		end else if (wp == IDX_W'(2)) begin
			ipd_d = ipd_q && (rx_byte == CH_P);
		end else if (wp == IDX_W'(3)) begin
			ipd_d = ipd_q && (rx_byte == CH_D);
		end else begin
			ipd_d = ipd_q;
		end
	end

	// number scan: first stored byte is skipped, a non-digit ends a number
	always_comb begin
		phase_d = phase_q;
		id_d    = id_acc_q;
		sz_d    = sz_acc_q;
		if (wp == '0) begin
			phase_d = P_SEEK_ID;
		end else begin
			case (phase_q)
				P_SEEK_ID: begin
					if (is_dig) begin
						phase_d = P_ID;
						id_d    = {4'b0000, dig};
					end
				end
				P_ID: begin
					if (is_dig) id_d = id_sat;
					else phase_d = P_SEEK_SZ;
				end
				P_SEEK_SZ: begin
					if (is_dig) begin
						phase_d = P_SZ;
						sz_d    = {12'h000, dig};
					end
				end
				P_SZ: begin
					if (is_dig) sz_d = sz_sat;
					else phase_d = P_DONE;
				end
				P_DONE: phase_d = P_DONE;
				default: phase_d = P_SEEK_ID;
			endcase
		end
	end

	assign gate_push = (trim_d >= CNT_W'(READY_LEN)) && rm_d;
	assign gate_hold = (trim_q >= CNT_W'(READY_LEN)) && rm_q;
	assign em_last   = (CNT_W'(em_idx_q) + CNT_W'(1)) == len_q;
	assign load_any  = cmd.load_pay || cmd.load_marker || cmd.load_line;

	always_comb begin
		sts.eol       = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		sts.blank     = is_blank;
		sts.plus      = rx_byte == CH_PLUS;
		sts.gt        = rx_byte == CH_GT;
		sts.colon     = rx_byte == CH_COLON;
		sts.go_push   = (trim_d != '0) && (ready_seen_q || gate_push);
		sts.go_hold   = (trim_q != '0) && (ready_seen_q || gate_hold);
		sts.ipd_hit   = (wi_d >= CNT_W'(IPD_MIN)) && ipd_d && (phase_d == P_DONE);
		sts.size_zero = sz_d == '0;
		sts.left_zero = left_q == '0;
		sts.pay_last  = left_q == 16'd1;
		sts.em_last   = em_last;
		sts.out_free  = !valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q         <= '0;
			trim_q       <= '0;
			len_q        <= '0;
			em_idx_q     <= '0;
			rm_q         <= 1'b0;
			ipd_q        <= 1'b0;
			ready_seen_q <= 1'b0;
			phase_q      <= P_SEEK_ID;
			pid_q        <= '0;
			left_q       <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (cmd.push) begin
				rm_q    <= rm_d;
				ipd_q   <= ipd_d;
				phase_q <= phase_d;
			end
			if (cmd.flush || cmd.ipd_take) begin
				wi_q   <= '0;
				trim_q <= '0;
			end else if (cmd.push) begin
				wi_q   <= wi_d;
				trim_q <= trim_d;
			end
			if (cmd.flush) begin
				len_q        <= cmd.push ? trim_d : trim_q;
				ready_seen_q <= ready_seen_q || (cmd.push ? gate_push : gate_hold);
				em_idx_q     <= '0;
			end
			if (cmd.ipd_take) begin
				pid_q  <= id_d;
				left_q <= sz_d;
			end
			if (cmd.dec_left) left_q <= left_q - 16'd1;
			if (cmd.load_line) em_idx_q <= em_idx_q + IDX_W'(1);
			if (load_any) valid_q <= 1'b1;
			else if (!out_stall) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp]  <= rx_byte;
			id_acc_q <= id_d;
			sz_acc_q <= sz_d;
		end
		if (cmd.rd) rd_q <= mem[em_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pay) begin
			kind_q <= KIND_PAY;
			byte_q <= rx_byte;
			cid_q  <= pid_q;
			last_q <= left_q == 16'd1;
		end else if (cmd.load_marker) begin
			kind_q <= KIND_MARK;
			byte_q <= '0;
			cid_q  <= id_d;
			last_q <= 1'b1;
		end else if (cmd.load_line) begin
			kind_q <= KIND_LINE;
			byte_q <= rd_q;
			cid_q  <= '0;
			last_q <= em_last;
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign conn_id   = cid_q;
	assign last      = last_q;

	`ARPL_ASSERT_NOW(a_wi_range, 1'b1, wi_q <= CNT_W'(LINE_LEN), "write index past line length")
	`ARPL_ASSERT_NOW(a_rd_in_line, cmd.rd, CNT_W'(em_idx_q) < len_q, "line read past length")
	`ARPL_ASSERT_NOW(a_dec_live, cmd.dec_left, left_q != '0, "payload count underflow")

endmodule

FILE: rtl/arpl_ctrl.sv
// Controller: parse mode and line emission sequencer.
`include "at_reply_line_and_ipd_parser_macros.svh"
module arpl_ctrl import arpl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  arpl_sts_t sts,
	output arpl_cmd_t cmd
);

	typedef enum logic [3:0] {
		M_IDLE    = 4'b0001,
		M_LINE    = 4'b0010,
		M_PLUS    = 4'b0100,
		M_PAYLOAD = 4'b1000
	} mode_t;

	typedef enum logic [2:0] {
		S_ACCEPT = 3'b001,
		S_READ   = 3'b010,
		S_LOAD   = 3'b100
	} seq_t;

	mode_t mode_q, mode_d;
	seq_t  seq_q, seq_d;
	logic  acc;

	assign in_stall = !((seq_q == S_ACCEPT) && sts.out_free);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		mode_d = mode_q;
		seq_d  = seq_q;
		cmd    = '0;
		case (seq_q)
			S_ACCEPT: begin
				if (acc) begin
					case (mode_q)
						M_PAYLOAD: begin
							if (sts.left_zero) begin
								mode_d = M_IDLE;
							end else begin
								cmd.load_pay = 1'b1;
								cmd.dec_left = 1'b1;
								if (sts.pay_last) mode_d = M_IDLE;
							end
						end
						M_IDLE: begin
							if (!sts.eol && !sts.blank) begin
								cmd.push = 1'b1;
								if (sts.plus) begin
									mode_d = M_PLUS;
								end else if (sts.gt) begin
									cmd.flush = 1'b1;
									if (sts.go_push) seq_d = S_READ;
								end else begin
									mode_d = M_LINE;
								end
							end
						end
						M_LINE: begin
							if (sts.eol) begin
								cmd.flush = 1'b1;
								mode_d    = M_IDLE;
								if (sts.go_hold) seq_d = S_READ;
							end else begin
								cmd.push = 1'b1;
							end
						end
						M_PLUS: begin
							if (sts.eol) begin
								cmd.flush = 1'b1;
								mode_d    = M_IDLE;
								if (sts.go_hold) seq_d = S_READ;
							end else begin
								cmd.push = 1'b1;
								if (sts.colon) begin
									if (sts.ipd_hit) begin
										cmd.ipd_take = 1'b1;
										if (sts.size_zero) begin
											cmd.load_marker = 1'b1;
											mode_d          = M_IDLE;
										end else begin
											mode_d = M_PAYLOAD;
										end
									end else begin
										mode_d = M_LINE;
									end
								end
							end
						end
						default: mode_d = M_IDLE;
					endcase
				end
			end
			S_READ: begin
				cmd.rd = 1'b1;
				seq_d  = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.load_line = 1'b1;
					seq_d         = sts.em_last ? S_ACCEPT : S_READ;
				end
			end
			default: seq_d = S_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			seq_q  <= S_ACCEPT;
		end else begin
			mode_q <= mode_d;
			seq_q  <= seq_d;
		end
	end

	`ARPL_ASSERT_NOW(a_emit_from_idle, seq_q != S_ACCEPT, mode_q == M_IDLE, "emit outside idle")
	`ARPL_ASSERT_NOW(a_cmd_excl, cmd.flush, !cmd.ipd_take && !cmd.load_pay && !cmd.load_marker, "flush overlaps payload command")
	`ARPL_ASSERT_NEXT(a_read_then_load, seq_q == S_READ, seq_q == S_LOAD, "read not followed by load")

endmodule

FILE: rtl/at_reply_line_and_ipd_parser.sv
// Top level: modem reply-line collector and IPD payload extractor.
// Payload beats and the empty marker reach the output in the cycle after the input beat.
// From the first line starting with ready on, each line is emitted after its terminating
// beat, byte by byte (store read, then output register load); input is stalled meanwhile
// and while the output is held. Line store is a 32-entry memory with one read port.
// Asynchronous active-low reset clears all control state; no store clearing pass.
module at_reply_line_and_ipd_parser import arpl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [7:0] conn_id,
	output logic       last
);

	arpl_cmd_t cmd;
	arpl_sts_t sts;

	arpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpl_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.out_byte  (out_byte),
		.conn_id   (conn_id),
		.last      (last)
	);

endmodule
